### rtl/bbp_pkg.sv
`timescale 1ns / 1ps
package bbp_pkg;

  localparam int FRAC_BITS        = 16;
  localparam int CONTROL_POINTS   = 16;
  localparam int MAX_TESSELLATION = 64;

  // fixed point one and one half for the parameter words
  localparam logic [17:0] ONE_Q  = 18'h10000;
  localparam logic [33:0] HALF_Q = 34'h08000;

  // operation of one issue slot of the multiply-accumulate lanes
  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_ROW  = 2'd1;
  localparam logic [1:0] OP_COL  = 2'd2;

  typedef logic [3:0][17:0] bbp_wgt_t;

  // one issue slot: memory read address, weight and accumulate mode
  typedef struct packed {
    logic [1:0]  op;
    logic        clr;
    logic [3:0]  addr;
    logic [17:0] wgt;
  } bbp_ctl_t;

  // control point write port
  typedef struct packed {
    logic        en;
    logic [3:0]  slot;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } bbp_wr_t;

  // product of two Q1.16 values rounded half up
  function automatic logic [16:0] mulq(input logic [16:0] a, input logic [16:0] b);
    logic [33:0] p;
    p = 34'(a) * 34'(b) + HALF_Q;
    return p[32:16];
  endfunction

  // corner emitted at each output position: A C D A D B
  function automatic logic [1:0] corner_of(input logic [2:0] idx);
    logic [1:0] c;
    case (idx)
      3'd0:    c = 2'd0;
      3'd1:    c = 2'd2;
      3'd2:    c = 2'd3;
      3'd3:    c = 2'd0;
      3'd4:    c = 2'd3;
      3'd5:    c = 2'd1;
      default: c = 2'd0;
    endcase
    return c;
  endfunction

endpackage

### rtl/bbp_div.sv
`timescale 1ns / 1ps
module bbp_div import bbp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [6:0]  num_i,
  input  logic [6:0]  den_i,
  output logic        done_o,
  output logic [16:0] quo_o
);

  logic [22:0] dvd_q, dvd_d;
  logic [6:0]  rem_q, rem_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [7:0]  trial;
  logic        ge;

  // one restoring step per cycle on (num << 16) / den
  assign trial = {rem_q, dvd_q[22]};
  assign ge    = trial >= {1'b0, den_i};

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = {num_i, 16'h0000};
      rem_d  = '0;
      cnt_d  = 5'd22;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? 7'(trial - {1'b0, den_i}) : trial[6:0];
      dvd_d = {dvd_q[21:0], ge};
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quo_o  = dvd_q[16:0];

endmodule

### rtl/bbp_weight.sv
`timescale 1ns / 1ps
module bbp_weight import bbp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [16:0] t_i,
  output logic        valid_o,
  output bbp_wgt_t    wgt_o
);

  logic [16:0] s;
  logic [16:0] s_q, t_q, ss_q, tt_q;
  logic [16:0] m1, m2;
  logic        va_q, vb_q;
  bbp_wgt_t    wgt_q;

  assign s = 17'(ONE_Q - {1'b0, t_i});

  // first stage: squares of s and t
  always_ff @(posedge clk_i) begin
    s_q  <= s;
    t_q  <= t_i;
    ss_q <= mulq(s, s);
    tt_q <= mulq(t_i, t_i);
  end

  assign m1 = mulq(ss_q, t_q);
  assign m2 = mulq(s_q, tt_q);

  // second stage: the four cubic weights
  always_ff @(posedge clk_i) begin
    wgt_q[0] <= {1'b0, mulq(ss_q, s_q)};
    wgt_q[1] <= 18'({1'b0, m1}) + 18'({m1, 1'b0});
    wgt_q[2] <= 18'({1'b0, m2}) + 18'({m2, 1'b0});
    wgt_q[3] <= {1'b0, mulq(tt_q, t_q)};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      va_q <= start_i;
      vb_q <= va_q;
    end
  end

  assign valid_o = vb_q;
  assign wgt_o   = wgt_q;

endmodule

### rtl/bbp_eval.sv
`timescale 1ns / 1ps
module bbp_eval import bbp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  bbp_wr_t     wr_i,
  input  bbp_ctl_t    ctl_i,
  output logic [31:0] res_x_o,
  output logic [31:0] res_y_o,
  output logic [31:0] res_z_o
);

  logic [95:0] mem [CONTROL_POINTS];
  logic [95:0] rd_q;
  logic [1:0]  op1_q, op2_q;
  logic        clr1_q, clr2_q;
  logic [17:0] w1_q;
  logic [2:0][31:0] res;

  // control point memory, x y z side by side
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.slot] <= {wr_i.x, wr_i.y, wr_i.z};
    end
    rd_q <= mem[ctl_i.addr];
    w1_q <= ctl_i.wgt;
  end

  // issue slot control follows the data through the pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op1_q  <= OP_NONE;
      op2_q  <= OP_NONE;
      clr1_q <= 1'b0;
      clr2_q <= 1'b0;
    end else begin
      op1_q  <= ctl_i.op;
      op2_q  <= op1_q;
      clr1_q <= ctl_i.clr;
      clr2_q <= clr1_q;
    end
  end

  // one multiply-accumulate lane per coordinate
  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic signed [31:0] pt;
    logic signed [36:0] a;
    logic signed [18:0] b;
    logic signed [55:0] prod_q;
    logic signed [52:0] rowacc_q;
    logic signed [52:0] rsum;
    logic signed [36:0] rowres_q;
    logic signed [57:0] acc_q;
    logic signed [57:0] fsum;

    assign pt = rd_q[95-32*l -: 32];
    assign a  = (op1_q == OP_ROW) ? {{5{pt[31]}}, pt} : rowres_q;
    assign b  = {1'b0, w1_q};
    assign rsum = rowacc_q + 53'sd32768;
    assign fsum = acc_q + 58'sd32768;

    always_ff @(posedge clk_i) begin
      prod_q   <= a * b;
      rowres_q <= rsum[52:16];
      if (op2_q == OP_ROW) begin
        rowacc_q <= (clr2_q ? 53'sd0 : rowacc_q) + prod_q[52:0];
      end
      if (op2_q == OP_COL) begin
        acc_q <= (clr2_q ? 58'sd0 : acc_q) + {{2{prod_q[55]}}, prod_q};
      end
    end

    assign res[l] = fsum[47:16];
  end

  assign res_x_o = res[0];
  assign res_y_o = res[1];
  assign res_z_o = res[2];

endmodule

### rtl/bicubic_bezier_patch_tessellator.sv
`timescale 1ns / 1ps
// Bicubic Bezier patch tessellator.
// Input channel (in_valid_i / in_ready_o): a load word (req_type_i = 0) writes
// one control point slot on its accepting edge and gives no output. An
// evaluate word (req_type_i = 1) names a grid cell and yields six vertex words
// in the order A C D A D B, last_vertex_o set on the sixth; a cell at or past
// the tessellation yields one word with cell_error_o and last_vertex_o set and
// zero vertices.
// Config channel (cfg_valid_i / cfg_ready_o): writes the tessellation, always
// ready; write it only while the block is idle. Reset value is 4.
// An evaluate word goes from its accepting edge to its first vertex through
// four parameters, each with start, 23 divide steps, done and two weight
// stages, then four corners on the shared multiply-accumulate lanes that read
// the control point memory (four rows of seven issue slots, then three states
// to drain and capture), and one step to load the output. The six vertices
// leave one per cycle while out_ready_i does not hold the output register.
// in_ready_o is high only when idle. The output register holds a vertex while
// out_ready_i is low and the sequencer waits; the next word is accepted while
// the last vertex still waits. Reset clears the control but not the memory:
// load every slot first.
module bicubic_bezier_patch_tessellator import bbp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [6:0]         cfg_tessellation_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               req_type_i,
  input  logic [3:0]         point_slot_i,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] point_z_i,
  input  logic [5:0]         cell_u_i,
  input  logic [5:0]         cell_v_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] vertex_x_o,
  output logic signed [31:0] vertex_y_o,
  output logic signed [31:0] vertex_z_o,
  output logic               cell_error_o,
  output logic               last_vertex_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DSTART = 4'd1;
  localparam logic [3:0] S_DWAIT  = 4'd2;
  localparam logic [3:0] S_WWAIT  = 4'd3;
  localparam logic [3:0] S_EVAL   = 4'd4;
  localparam logic [3:0] S_D1     = 4'd5;
  localparam logic [3:0] S_D2     = 4'd6;
  localparam logic [3:0] S_CAP    = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;
  localparam logic [3:0] S_ERR    = 4'd9;

  logic [3:0]  state_q, state_d;
  logic [6:0]  tess_q;
  logic [6:0]  tc;
  logic [5:0]  cu_q, cv_q;
  logic [1:0]  p_q, p_d;
  logic [1:0]  r_q, r_d;
  logic [2:0]  k_q, k_d;
  logic [1:0]  c_q, c_d;
  logic [2:0]  o_q, o_d;
  logic        bad_cell;

  logic        div_start, div_done;
  logic [16:0] quo;
  logic [6:0]  div_num;
  logic        wgt_valid;
  bbp_wgt_t    wgt;
  bbp_wgt_t    wu_q [2];
  bbp_wgt_t    wv_q [2];

  bbp_ctl_t    ctl;
  bbp_wr_t     wr;
  logic [31:0] rx, ry, rz;
  logic [95:0] cor_q [4];
  logic [95:0] cor_rd;

  logic        load_out, out_valid_q;
  logic [31:0] vx_q, vy_q, vz_q;
  logic        err_q, last_q;
  logic [95:0] vtx_d;
  logic        err_d, last_d;

  // tessellation register and its clamp
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tess_q <= 7'd4;
    end else if (cfg_valid_i) begin
      tess_q <= cfg_tessellation_i;
    end
  end
  assign cfg_ready_o = 1'b1;
  assign tc = (tess_q > 7'(MAX_TESSELLATION)) ? 7'(MAX_TESSELLATION) : tess_q;
  assign bad_cell = (tc == 7'd0) || ({1'b0, cell_u_i} >= tc) || ({1'b0, cell_v_i} >= tc);

  assign in_ready_o = (state_q == S_IDLE);

  // parameter divider and weight unit
  assign div_start = (state_q == S_DSTART);
  assign div_num   = 7'(p_q[1] ? cv_q : cu_q) + 7'(p_q[0]);

  bbp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (tc),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  bbp_weight u_weight (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_done),
    .t_i     (quo),
    .valid_o (wgt_valid),
    .wgt_o   (wgt)
  );

  always_ff @(posedge clk_i) begin
    if (state_q == S_WWAIT && wgt_valid) begin
      if (p_q[1]) begin
        wv_q[p_q[0]] <= wgt;
      end else begin
        wu_q[p_q[0]] <= wgt;
      end
    end
  end

  // issue slots: four row products then one column product per row
  always_comb begin
    ctl      = '0;
    ctl.op   = OP_NONE;
    ctl.addr = {r_q, k_q[1:0]};
    if (state_q == S_EVAL) begin
      if (k_q < 3'd4) begin
        ctl.op  = OP_ROW;
        ctl.clr = (k_q == 3'd0);
        ctl.wgt = wu_q[c_q[1]][k_q[1:0]];
      end else if (k_q == 3'd6) begin
        ctl.op  = OP_COL;
        ctl.clr = (r_q == 2'd0);
        ctl.wgt = wv_q[c_q[0]][r_q];
      end
    end
  end

  assign wr.en   = in_valid_i && in_ready_o && !req_type_i;
  assign wr.slot = point_slot_i;
  assign wr.x    = point_x_i;
  assign wr.y    = point_y_i;
  assign wr.z    = point_z_i;

  bbp_eval u_eval (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (wr),
    .ctl_i   (ctl),
    .res_x_o (rx),
    .res_y_o (ry),
    .res_z_o (rz)
  );

  // corner store and cell latch
  always_ff @(posedge clk_i) begin
    if (state_q == S_CAP) begin
      cor_q[c_q] <= {rx, ry, rz};
    end
    if (in_valid_i && in_ready_o) begin
      cu_q <= cell_u_i;
      cv_q <= cell_v_i;
    end
  end
  assign cor_rd = cor_q[corner_of(o_q)];

  // sequencer
  always_comb begin
    state_d  = state_q;
    p_d      = p_q;
    r_d      = r_q;
    k_d      = k_q;
    c_d      = c_q;
    o_d      = o_q;
    load_out = 1'b0;
    vtx_d    = cor_rd;
    err_d    = 1'b0;
    last_d   = (o_q == 3'd5);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && req_type_i) begin
          p_d     = '0;
          state_d = bad_cell ? S_ERR : S_DSTART;
        end
      end
      S_DSTART: state_d = S_DWAIT;
      S_DWAIT: begin
        if (div_done) begin
          state_d = S_WWAIT;
        end
      end
      S_WWAIT: begin
        if (wgt_valid) begin
          if (p_q == 2'd3) begin
            r_d     = '0;
            k_d     = '0;
            c_d     = '0;
            state_d = S_EVAL;
          end else begin
            p_d     = p_q + 2'd1;
            state_d = S_DSTART;
          end
        end
      end
      S_EVAL: begin
        if (k_q == 3'd6) begin
          k_d = '0;
          if (r_q == 2'd3) begin
            state_d = S_D1;
          end else begin
            r_d = r_q + 2'd1;
          end
        end else begin
          k_d = k_q + 3'd1;
        end
      end
      S_D1: state_d = S_D2;
      S_D2: state_d = S_CAP;
      S_CAP: begin
        r_d = '0;
        k_d = '0;
        if (c_q == 2'd3) begin
          o_d     = '0;
          state_d = S_OUT;
        end else begin
          c_d     = c_q + 2'd1;
          state_d = S_EVAL;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          if (o_q == 3'd5) begin
            state_d = S_IDLE;
          end else begin
            o_d = o_q + 3'd1;
          end
        end
      end
      S_ERR: begin
        vtx_d  = '0;
        err_d  = 1'b1;
        last_d = 1'b1;
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      p_q         <= '0;
      r_q         <= '0;
      k_q         <= '0;
      c_q         <= '0;
      o_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      p_q     <= p_d;
      r_q     <= r_d;
      k_q     <= k_d;
      c_q     <= c_d;
      o_q     <= o_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output word register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      vx_q   <= vtx_d[95:64];
      vy_q   <= vtx_d[63:32];
      vz_q   <= vtx_d[31:0];
      err_q  <= err_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign vertex_x_o    = vx_q;
  assign vertex_y_o    = vy_q;
  assign vertex_z_o    = vz_q;
  assign cell_error_o  = err_q;
  assign last_vertex_o = last_q;

endmodule

### rtl/bbp_checker.sv
`timescale 1ns / 1ps
module bbp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               req_type_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [31:0] vertex_x_o,
  input logic signed [31:0] vertex_y_o,
  input logic signed [31:0] vertex_z_o,
  input logic               cell_error_o,
  input logic               last_vertex_o
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(vertex_x_o)
      && $stable(vertex_y_o) && $stable(vertex_z_o) && $stable(last_vertex_o))
    else $error("stalled output word changed");

  // an error word is a lone zero word
  a_err_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cell_error_o |-> last_vertex_o && vertex_x_o == 32'sd0
      && vertex_y_o == 32'sd0 && vertex_z_o == 32'sd0)
    else $error("error word not a lone zero word");

  // an accepted evaluate word blocks the input
  a_eval_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && req_type_i |=> !in_ready_o)
    else $error("input taken during evaluation");

endmodule

bind bicubic_bezier_patch_tessellator bbp_checker u_bbp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .req_type_i    (req_type_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .vertex_x_o    (vertex_x_o),
  .vertex_y_o    (vertex_y_o),
  .vertex_z_o    (vertex_z_o),
  .cell_error_o  (cell_error_o),
  .last_vertex_o (last_vertex_o)
);

### tb/tb_bicubic_bezier_patch_tessellator.sv
`timescale 1ns / 1ps
module tb_bicubic_bezier_patch_tessellator;
  import bbp_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = 300;
  localparam int HOLD_CYCLES = 3000;

  typedef struct {
    bit                 is_eval;
    logic [3:0]         slot;
    logic signed [31:0] x, y, z;
    logic [5:0]         cu, cv;
  } req_word_t;

  typedef struct {
    logic signed [31:0] x, y, z;
    logic               err;
    logic               last;
  } vertex_word_t;

  typedef longint bern_t [4];

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [6:0]         cfg_tessellation_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic               req_type_i = 1'b0;
  logic [3:0]         point_slot_i = '0;
  logic signed [31:0] point_x_i = '0;
  logic signed [31:0] point_y_i = '0;
  logic signed [31:0] point_z_i = '0;
  logic [5:0]         cell_u_i = '0;
  logic [5:0]         cell_v_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [31:0] vertex_x_o, vertex_y_o, vertex_z_o;
  logic               cell_error_o, last_vertex_o;

  bicubic_bezier_patch_tessellator dut (.*);

  always #10 clk_i = ~clk_i;

  // predictor state
  logic signed [31:0] ctrl_pts [3][16];
  int unsigned        tess_cur = 4;
  vertex_word_t       pending_vertices [$];
  int                 fail_count = 0;
  int                 burst_left = 0;
  bit                 hold_req = 1'b0;
  int                 cycle_count = 0;

  // rounded product of two parameter values
  function automatic longint unsigned qmul(longint unsigned a, longint unsigned b);
    return (a * b + 64'd32768) >> FRAC_BITS;
  endfunction

  // floor((v + half) / one)
  function automatic longint qround(longint v);
    return (v + 64'sd32768) >>> FRAC_BITS;
  endfunction

  function automatic bern_t bernstein(longint unsigned t);
    bern_t w;
    longint unsigned s, ss, tt;
    s = 65536 - t;
    ss = qmul(s, s);
    tt = qmul(t, t);
    w[0] = qmul(ss, s);
    w[1] = 3 * qmul(ss, t);
    w[2] = 3 * qmul(s, tt);
    w[3] = qmul(tt, t);
    return w;
  endfunction

  function automatic logic signed [31:0] patch_coord(int c, bern_t wu, bern_t wv);
    longint acc, row;
    acc = 0;
    for (int r = 0; r < 4; r++) begin
      row = 0;
      for (int k = 0; k < 4; k++) row += wu[k] * longint'(ctrl_pts[c][r*4+k]);
      acc += wv[r] * qround(row);
    end
    return 32'(qround(acc));
  endfunction

  function automatic vertex_word_t patch_point(longint unsigned u, longint unsigned v);
    vertex_word_t p;
    bern_t wu, wv;
    wu = bernstein(u);
    wv = bernstein(v);
    p.x = patch_coord(0, wu, wv);
    p.y = patch_coord(1, wu, wv);
    p.z = patch_coord(2, wu, wv);
    p.err = 1'b0;
    p.last = 1'b0;
    return p;
  endfunction

  // update point store or queue the vertices of one cell
  function automatic void predict_word(req_word_t w);
    vertex_word_t corner [4];
    vertex_word_t vw;
    int order [6] = '{0, 2, 3, 0, 3, 1};
    longint unsigned t, u0, u1, v0, v1;
    if (!w.is_eval) begin
      ctrl_pts[0][w.slot] = w.x;
      ctrl_pts[1][w.slot] = w.y;
      ctrl_pts[2][w.slot] = w.z;
      return;
    end
    t = (tess_cur > MAX_TESSELLATION) ? MAX_TESSELLATION : tess_cur;
    if (t == 0 || w.cu >= t || w.cv >= t) begin
      vw = '{x: 0, y: 0, z: 0, err: 1'b1, last: 1'b1};
      pending_vertices.push_back(vw);
      return;
    end
    u0 = (longint'(w.cu) * 65536) / t;
    u1 = ((longint'(w.cu) + 1) * 65536) / t;
    v0 = (longint'(w.cv) * 65536) / t;
    v1 = ((longint'(w.cv) + 1) * 65536) / t;
    corner[0] = patch_point(u0, v0);
    corner[1] = patch_point(u0, v1);
    corner[2] = patch_point(u1, v0);
    corner[3] = patch_point(u1, v1);
    for (int i = 0; i < 6; i++) begin
      vw = corner[order[i]];
      vw.last = (i == 5);
      pending_vertices.push_back(vw);
    end
  endfunction

  // send one word; bursts of random length with random gaps between them
  task automatic send_word(req_word_t w);
    in_valid_i   <= 1'b1;
    req_type_i   <= w.is_eval;
    point_slot_i <= w.slot;
    point_x_i    <= w.x;
    point_y_i    <= w.y;
    point_z_i    <= w.z;
    cell_u_i     <= w.cu;
    cell_v_i     <= w.cv;
    do @(posedge clk_i); while (!in_ready_o);
    predict_word(w);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = $urandom_range(1, 10);
    end
  endtask

  function automatic req_word_t load_word(int slot, logic [31:0] x, logic [31:0] y,
                                         logic [31:0] z);
    req_word_t w;
    w = '{is_eval: 1'b0, slot: 4'(slot), x: x, y: y, z: z,
          cu: 6'($urandom), cv: 6'($urandom)};
    return w;
  endfunction

  function automatic req_word_t eval_word(int cu, int cv);
    req_word_t w;
    w = '{is_eval: 1'b1, slot: 4'($urandom), x: $urandom, y: $urandom, z: $urandom,
          cu: 6'(cu), cv: 6'(cv)};
    return w;
  endfunction

  // stop sending and wait until every vertex has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending_vertices.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_tessellation(int unsigned t);
    drain();
    cfg_valid_i        <= 1'b1;
    cfg_tessellation_i <= 7'(t);
    do @(posedge clk_i); while (!cfg_ready_o);
    tess_cur = t & 7'h7f;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] coord_value();
    case ($urandom_range(0, 5))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'($urandom_range(0, 'h3ffff)) - 32'h2_0000;
      default: return $urandom;
    endcase
  endfunction

  // load all sixteen points, extremes included
  task automatic test_load_points();
    for (int k = 0; k < 16; k++) begin
      case (k)
        0:       send_word(load_word(k, 32'h8000_0000, 32'h7fff_ffff, 32'h0));
        1:       send_word(load_word(k, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff));
        2:       send_word(load_word(k, 32'hffff_ffff, 32'h0, 32'h8000_0000));
        default: send_word(load_word(k, coord_value(), coord_value(), coord_value()));
      endcase
    end
  endtask

  // edge cells and out-of-range cells at the reset tessellation
  task automatic test_cell_edges();
    send_word(eval_word(0, 0));
    send_word(eval_word(3, 3));
    send_word(eval_word(0, 3));
    send_word(eval_word(4, 0));
    send_word(eval_word(0, 63));
    send_word(eval_word(63, 63));
  endtask

  // tessellation extremes: one, max, zero and above max
  task automatic test_tessellation_extremes();
    set_tessellation(1);
    send_word(eval_word(0, 0));
    send_word(eval_word(1, 0));
    set_tessellation(64);
    send_word(eval_word(63, 0));
    send_word(eval_word(0, 63));
    send_word(eval_word(63, 63));
    set_tessellation(0);
    send_word(eval_word(0, 0));
    set_tessellation(127);
    send_word(eval_word(63, 62));
    send_word(eval_word(21, 42));
  endtask

  // receiver holds off while words keep coming, then a full pause
  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int i = 0; i < 5; i++) send_word(eval_word($urandom_range(0, 63), $urandom_range(0, 63)));
    send_word(load_word($urandom_range(0, 15), coord_value(), coord_value(), coord_value()));
    drain();
  endtask

  task automatic test_random_mix();
    req_word_t w;
    int unsigned t;
    for (int n = 0; n < 420; n++) begin
      if (n % 84 == 83) begin
        t = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 64);
        set_tessellation(t);
      end
      t = (tess_cur > 64) ? 64 : tess_cur;
      if ($urandom_range(0, 9) < 3)
        w = load_word($urandom_range(0, 15), coord_value(), coord_value(), coord_value());
      else if ($urandom_range(0, 9) == 0 || t == 0)
        w = eval_word($urandom_range(0, 63), $urandom_range(0, 63));
      else
        w = eval_word($urandom_range(0, t - 1), $urandom_range(0, t - 1));
      send_word(w);
    end
  endtask

  // receiver stall pattern, with one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req) begin
      out_ready_i <= 1'b0;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      hold_req = 1'b0;
    end else if ((cycle_count / 2000) % 3 == 0) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(0, 3) != 0);
    end
  end

  // compare each vertex word with the oldest expectation
  always @(posedge clk_i) begin
    vertex_word_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_vertices.size() == 0) begin
        $error("unexpected vertex word x=%0d y=%0d z=%0d", vertex_x_o, vertex_y_o, vertex_z_o);
        fail_count++;
      end else begin
        e = pending_vertices.pop_front();
        if (vertex_x_o !== e.x) begin
          $error("vertex_x exp %0d got %0d", e.x, vertex_x_o);
          fail_count++;
        end
        if (vertex_y_o !== e.y) begin
          $error("vertex_y exp %0d got %0d", e.y, vertex_y_o);
          fail_count++;
        end
        if (vertex_z_o !== e.z) begin
          $error("vertex_z exp %0d got %0d", e.z, vertex_z_o);
          fail_count++;
        end
        if (cell_error_o !== e.err) begin
          $error("cell_error exp %0d got %0d", e.err, cell_error_o);
          fail_count++;
        end
        if (last_vertex_o !== e.last) begin
          $error("last_vertex exp %0d got %0d", e.last, last_vertex_o);
          fail_count++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    burst_left = $urandom_range(1, 10);
    test_load_points();
    test_cell_edges();
    test_tessellation_extremes();
    set_tessellation(4);
    test_backpressure();
    test_random_mix();
    drain();
    if (fail_count == 0 && pending_vertices.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
